@@ sv/smd_pkg.sv @@
`default_nettype none

package smd_pkg;

  // Fixed field widths of the stream items
  localparam int POS_W    = 6;
  localparam int RAW_W    = 16;
  localparam int LENCFG_W = 7;
  localparam int DIST_W   = 40;

  localparam logic [DIST_W-1:0] DIST_MAX = '1;

  // Per-cell control, one group per tap
  typedef struct packed {
    logic load;    // write the tap's shapelet sample
    logic update;  // take the neighbor's sum plus this tap's square
    logic clear;   // zero the partial sum at end of row
  } cell_ctl_t;

endpackage

`default_nettype wire

@@ sv/smd_cell.sv @@
`default_nettype none

module smd_cell import smd_pkg::*; #(
  parameter int SAMPLE_BITS = 16
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire cell_ctl_t                     ctl,
  input  wire logic signed [SAMPLE_BITS-1:0] sample_x,
  input  wire logic [DIST_W-1:0]             sum_in,
  output logic [DIST_W-1:0]                  sum_out
);

  localparam int SQ_W  = 2 * SAMPLE_BITS;
  localparam int ACC_W = ((SQ_W > DIST_W) ? SQ_W : DIST_W) + 1;

  logic signed [SAMPLE_BITS-1:0] shape_r;
  logic [DIST_W-1:0]             sum_r;
  logic [DIST_W-1:0]             sum_nxt;
  logic signed [SAMPLE_BITS:0]   diff;
  logic signed [SAMPLE_BITS:0]   diff_neg;
  logic [SAMPLE_BITS-1:0]        mag;
  logic [SQ_W-1:0]               sq;
  logic [ACC_W-1:0]              acc;

  // Square of the distance between this tap and the incoming sample
  assign diff     = {shape_r[SAMPLE_BITS-1], shape_r} - {sample_x[SAMPLE_BITS-1], sample_x};
  assign diff_neg = -diff;
  assign mag      = diff[SAMPLE_BITS] ? diff_neg[SAMPLE_BITS-1:0] : diff[SAMPLE_BITS-1:0];
  assign sq       = SQ_W'(mag) * SQ_W'(mag);

  // Add to the neighbor's partial sum, saturate at the top of the range
  assign acc = ACC_W'(sum_in) + ACC_W'(sq);

  always_comb begin
    sum_nxt = sum_r;
    if (ctl.clear) begin
      sum_nxt = '0;
    end else if (ctl.update) begin
      sum_nxt = (acc > ACC_W'(DIST_MAX)) ? DIST_MAX : acc[DIST_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r <= '0;
    end else begin
      sum_r <= sum_nxt;
    end
  end

  // Hold the shapelet sample of this tap
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      shape_r <= sample_x;
    end
  end

  assign sum_out = sum_r;

endmodule

`default_nettype wire

@@ sv/shapelet_min_distance_core.sv @@
// Throughput: one item per cycle while in_tready is high; each tap cell within the shapelet
//   length does its multiply and saturating add in the cycle that a data sample is accepted.
// Result path: the row's last item updates the taps at the accepting edge and enters stage 1;
//   the minimum compare then loads the output register (stage 1 holds while that is full).
// Reset (rst_n low, synchronous): length 1, sums zero, best distance all ones, next
//   series item taken as a label; shapelet samples are not cleared.
`default_nettype none

module shapelet_min_distance_core import smd_pkg::*; #(
  parameter int MAX_SHAPELET_LEN = 64,
  parameter int SAMPLE_BITS      = 16
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  // configuration: shapelet_length
  input  wire logic                cfg_wr_en,
  input  wire logic [LENCFG_W-1:0] cfg_wr_data,
  // input items
  input  wire logic                in_tvalid,
  output logic                     in_tready,
  input  wire logic [23:0]         in_tdata,   // position[5:0], sample[21:6], zero pad
  input  wire logic                in_tuser,   // action
  input  wire logic                in_tlast,   // last
  // result items
  output logic                     out_tvalid,
  input  wire logic                out_tready,
  output logic [55:0]              out_tdata,  // label[15:0], min_distance[55:16]
  output logic                     out_tuser   // no_window
);

  localparam int LEN_W = $clog2(MAX_SHAPELET_LEN + 1);
  localparam int IDX_W = $clog2(MAX_SHAPELET_LEN);
  localparam int CMP_W = (LEN_W > LENCFG_W) ? LEN_W : LENCFG_W;

  logic [LENCFG_W-1:0] len_cfg_r;
  logic [LEN_W-1:0]    len_eff;
  logic [CMP_W-1:0]    len_cmp;
  logic [IDX_W-1:0]    tap_idx;

  logic [POS_W-1:0]              in_pos;
  logic [RAW_W-1:0]              in_raw;
  logic signed [SAMPLE_BITS-1:0] in_x;

  logic accept, load_acc, ser_acc, label_acc, data_acc;

  logic             awaiting_label_r;
  logic [RAW_W-1:0] row_label_r;
  logic [LEN_W-1:0] seen_r, seen_nxt, seen_after;

  logic             s1_v_r, s1_last_r, s1_cand_r, s1_nowin_r;
  logic [RAW_W-1:0] s1_label_r;
  logic             adv1, s1_fire, s1_end;

  logic [DIST_W-1:0] best_r, best_nxt, cand;
  logic              cand_win;

  logic              out_valid_r, out_nowin_r;
  logic [RAW_W-1:0]  out_label_r;
  logic [DIST_W-1:0] out_dist_r;

  logic [DIST_W-1:0] sums [MAX_SHAPELET_LEN];

  // Unpack the input item
  assign in_pos = in_tdata[POS_W-1:0];
  assign in_raw = in_tdata[POS_W +: RAW_W];

  generate
    if (SAMPLE_BITS <= RAW_W) begin : g_narrow
      assign in_x = in_raw[SAMPLE_BITS-1:0];
    end else begin : g_wide
      assign in_x = SAMPLE_BITS'(in_raw);
    end
  endgenerate

  // Configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_cfg_r <= LENCFG_W'(1);
    end else if (cfg_wr_en) begin
      len_cfg_r <= cfg_wr_data;
    end
  end

  // Clamp the length into 1 .. MAX_SHAPELET_LEN
  always_comb begin
    len_cmp = CMP_W'(len_cfg_r);
    if (len_cmp == '0) begin
      len_cmp = CMP_W'(1);
    end else if (len_cmp > CMP_W'(MAX_SHAPELET_LEN)) begin
      len_cmp = CMP_W'(MAX_SHAPELET_LEN);
    end
  end
  assign len_eff = len_cmp[LEN_W-1:0];
  assign tap_idx = IDX_W'(len_eff - LEN_W'(1));

  // Stall input only while a finished row cannot reach the output register
  assign adv1      = !(s1_v_r && s1_last_r && out_valid_r && !out_tready);
  assign in_tready = adv1;
  assign accept    = in_tvalid && in_tready;
  assign load_acc  = accept && !in_tuser;
  assign label_acc = accept && in_tuser && awaiting_label_r;
  assign ser_acc   = accept && in_tuser;
  assign data_acc  = ser_acc && !awaiting_label_r;
  assign s1_fire   = adv1 && s1_v_r;
  assign s1_end    = s1_fire && s1_last_r;

  // Chain of tap cells
  genvar j;
  generate
    for (j = 0; j < MAX_SHAPELET_LEN; j++) begin : g_tap
      cell_ctl_t        ctl;
      logic [DIST_W-1:0] prev;
      assign ctl.load   = load_acc && (int'(in_pos) == j);
      assign ctl.update = data_acc && (len_eff > LEN_W'(j));
      assign ctl.clear  = s1_end;
      if (j == 0) begin : g_first
        assign prev = '0;
      end else begin : g_next
        assign prev = sums[j-1];
      end
      smd_cell #(.SAMPLE_BITS(SAMPLE_BITS)) u_cell (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (ctl),
        .sample_x (in_x),
        .sum_in   (prev),
        .sum_out  (sums[j])
      );
    end
  endgenerate

  // Row bookkeeping at accept time
  assign seen_after = data_acc
                    ? ((seen_r < LEN_W'(MAX_SHAPELET_LEN)) ? seen_r + LEN_W'(1) : seen_r)
                    : seen_r;
  assign seen_nxt   = (ser_acc && in_tlast) ? '0 : seen_after;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      awaiting_label_r <= 1'b1;
      row_label_r      <= '0;
      seen_r           <= '0;
    end else begin
      seen_r <= seen_nxt;
      if (label_acc) begin
        row_label_r <= in_raw;
      end
      if (ser_acc) begin
        awaiting_label_r <= in_tlast;
      end else if (label_acc) begin
        awaiting_label_r <= 1'b0;
      end
    end
  end

  // Stage 1: carry what the compare needs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (adv1) begin
      s1_v_r <= ser_acc;
    end
  end

  always_ff @(posedge clk) begin
    if (adv1 && ser_acc) begin
      s1_last_r  <= in_tlast;
      s1_cand_r  <= data_acc && (seen_after >= len_eff);
      s1_nowin_r <= !(seen_after >= len_eff);
      s1_label_r <= awaiting_label_r ? in_raw : row_label_r;
    end
  end

  // Minimum over the windows of the row
  assign cand     = sums[tap_idx];
  assign cand_win = s1_cand_r && (cand < best_r);
  assign best_nxt = cand_win ? cand : best_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      best_r <= DIST_MAX;
    end else if (s1_end) begin
      best_r <= DIST_MAX;
    end else if (s1_fire) begin
      best_r <= best_nxt;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_end) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_end) begin
      out_label_r <= s1_label_r;
      out_dist_r  <= s1_nowin_r ? DIST_MAX : best_nxt;
      out_nowin_r <= s1_nowin_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_dist_r, out_label_r};
  assign out_tuser  = out_nowin_r;

  // A row without a window reports the top distance
  a_nowin_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_nowin_r |-> out_dist_r == DIST_MAX)
    else $error("no_window result without maximum distance");

  // The sample count never passes the chain length
  a_seen_bound: assert property (@(posedge clk) disable iff (!rst_n)
    seen_r <= LEN_W'(MAX_SHAPELET_LEN))
    else $error("sample count beyond chain length");

  // Input stalls only when a finished row waits on a full output register
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> s1_v_r && s1_last_r && out_valid_r)
    else $error("input stalled without a pending result");

endmodule

`default_nettype wire
